// ===== rtl/wshl_pkg.sv =====
// ----------------------------------------------------------------------------
// wshl_pkg
// Shared types and constants for the wheel slip haptic level unit.
// ----------------------------------------------------------------------------
package wshl_pkg;

    localparam int NUM_WHEELS = 4;
    localparam int RADIUS_W   = 16;
    localparam int OMEGA_W    = 16;
    localparam int SLIP_IN_W  = 10;
    localparam int SLIP_W     = 8;
    localparam int SPEED_W    = 9;
    localparam int LEVEL_W    = 7;
    localparam int THR_B_W    = 16;
    localparam int THR_G_W    = 17;
    localparam int PROD_W     = RADIUS_W + 1 + OMEGA_W;
    localparam int RIM_W      = 58;
    localparam int K100_W     = 26;
    localparam int FRAC_SHIFT = 36;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // rim speed scale 247065 folded with the percent factor 100
    localparam logic signed [K100_W-1:0] RIM_K100   = 26'sd24706500;
    localparam logic [SLIP_W-1:0]        SLIP_SAT   = 8'd255;
    localparam logic [SLIP_W-1:0]        LEVEL_MAX  = 8'd127;
    localparam logic [6:0]               PCT_FULL   = 7'd100;
    localparam logic [RADIUS_W-1:0]      RADIUS_RST = 16'd20000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RADIUS_FL = 3'd0,
        CFG_RADIUS_FR = 3'd1,
        CFG_RADIUS_RL = 3'd2,
        CFG_RADIUS_RR = 3'd3,
        CFG_BRAKE_PCT = 3'd4,
        CFG_GAS_PCT   = 3'd5,
        CFG_BUMP_LVL  = 3'd6
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_NONE  = 2'd0,
        ST_BRAKE = 2'd1,
        ST_GAS   = 2'd2
    } t_wstat;

    typedef struct packed {
        logic load;
        logic scale;
    } t_lane_ctl;

    typedef struct packed {
        logic [SLIP_IN_W-1:0]      slip_fl;
        logic [SLIP_IN_W-1:0]      slip_fr;
        logic [SLIP_IN_W-1:0]      slip_rl;
        logic [SLIP_IN_W-1:0]      slip_rr;
        logic signed [OMEGA_W-1:0] omega_fl;
        logic signed [OMEGA_W-1:0] omega_fr;
        logic signed [OMEGA_W-1:0] omega_rl;
        logic signed [OMEGA_W-1:0] omega_rr;
        logic [NUM_WHEELS-1:0]     load_zero;
        logic [SPEED_W-1:0]        speed_kmh;
    } t_in_beat;

    typedef struct packed {
        logic                  levels_valid;
        logic [LEVEL_W-1:0]    gas_level;
        logic [LEVEL_W-1:0]    brake_level;
        logic [1:0]            status_fl;
        logic [1:0]            status_fr;
        logic [1:0]            status_rl;
        logic [1:0]            status_rr;
        logic [NUM_WHEELS-1:0] status_changed;
        logic                  bumping;
        logic                  bumping_changed;
    } t_out_beat;

endpackage

// ===== rtl/wshl_lane.sv =====
// ----------------------------------------------------------------------------
// wshl_lane
// Per-wheel slip classifier: rim speed product and threshold compare.
// ----------------------------------------------------------------------------
module wshl_lane
    import wshl_pkg::*;
(
    input  logic                       i_clk,
    input  t_lane_ctl                  i_ctl,
    input  logic [RADIUS_W-1:0]        i_radius,
    input  logic signed [OMEGA_W-1:0]  i_omega,
    input  logic [SLIP_IN_W-1:0]       i_slip,
    input  logic [THR_B_W-1:0]         i_thr_brake,
    input  logic [THR_G_W-1:0]         i_thr_gas,
    output logic [SLIP_W-1:0]          o_slip,
    output t_wstat                     o_status
);

    logic signed [PROD_W-1:0]         r_prod;
    logic signed [PROD_W-1:0]         n_prod;
    logic signed [RIM_W-1:0]          r_rim;
    logic signed [RIM_W-1:0]          n_rim;
    logic signed [PROD_W+K100_W-1:0]  rim_full;
    logic signed [RIM_W-1:0]          thr_b;
    logic signed [RIM_W-1:0]          thr_g;

    assign n_prod   = $signed({1'b0, i_radius}) * i_omega;
    assign rim_full = r_prod * RIM_K100;
    assign n_rim    = rim_full[RIM_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_prod <= n_prod;
        end
        if (i_ctl.scale) begin
            r_rim <= n_rim;
        end
    end

    assign o_slip = (i_slip > SLIP_IN_W'(SLIP_SAT)) ? SLIP_SAT : i_slip[SLIP_W-1:0];

    assign thr_b = $signed({{(RIM_W-THR_B_W-FRAC_SHIFT){1'b0}}, i_thr_brake,
                            {FRAC_SHIFT{1'b0}}});
    assign thr_g = $signed({{(RIM_W-THR_G_W-FRAC_SHIFT){1'b0}}, i_thr_gas,
                            {FRAC_SHIFT{1'b0}}});

    always_comb begin
        if (o_slip == '0) begin
            o_status = ST_NONE;
        end else if (r_rim < thr_b) begin
            o_status = ST_BRAKE;
        end else if (r_rim > thr_g) begin
            o_status = ST_GAS;
        end else begin
            o_status = ST_NONE;
        end
    end

endmodule

// ===== rtl/wshl_merge.sv =====
// ----------------------------------------------------------------------------
// wshl_merge
// Combines lane results: slip maxima, bump floor, clamp and change flags.
// ----------------------------------------------------------------------------
module wshl_merge
    import wshl_pkg::*;
(
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_upd,
    input  t_wstat [NUM_WHEELS-1:0]            i_status,
    input  logic [NUM_WHEELS-1:0][SLIP_W-1:0]  i_slip,
    input  logic [NUM_WHEELS-1:0]              i_loads,
    input  logic [SLIP_W-1:0]                  i_bump_level,
    output t_out_beat                          o_beat
);

    logic [SLIP_W-1:0]         r_prev_brake;
    logic [SLIP_W-1:0]         r_prev_gas;
    t_wstat [NUM_WHEELS-1:0]   r_prev_status;
    logic                      r_prev_bump;

    logic [SLIP_W-1:0]         brake_raw;
    logic [SLIP_W-1:0]         gas_raw;
    logic [SLIP_W-1:0]         brake_max;
    logic [SLIP_W-1:0]         gas_max;
    logic                      bumping;
    logic [NUM_WHEELS-1:0]     changed;

    always_comb begin
        brake_raw = '0;
        gas_raw   = '0;
        for (int i = 0; i < NUM_WHEELS; i++) begin
            if (i_status[i] == ST_BRAKE && i_slip[i] > brake_raw) begin
                brake_raw = i_slip[i];
            end
            if (i_status[i] == ST_GAS && i_slip[i] > gas_raw) begin
                gas_raw = i_slip[i];
            end
            changed[i] = (i_status[i] != r_prev_status[i]);
        end
    end

    assign bumping   = (i_loads != '0);
    assign brake_max = (bumping && brake_raw < i_bump_level) ? i_bump_level : brake_raw;
    assign gas_max   = (bumping && gas_raw < i_bump_level) ? i_bump_level : gas_raw;

    always_comb begin
        o_beat.levels_valid    = (brake_max != r_prev_brake) || (gas_max != r_prev_gas);
        o_beat.gas_level       = (gas_max > LEVEL_MAX) ? LEVEL_MAX[LEVEL_W-1:0]
                                                       : gas_max[LEVEL_W-1:0];
        o_beat.brake_level     = (brake_max > LEVEL_MAX) ? LEVEL_MAX[LEVEL_W-1:0]
                                                         : brake_max[LEVEL_W-1:0];
        o_beat.status_fl       = i_status[0];
        o_beat.status_fr       = i_status[1];
        o_beat.status_rl       = i_status[2];
        o_beat.status_rr       = i_status[3];
        o_beat.status_changed  = changed;
        o_beat.bumping         = bumping;
        o_beat.bumping_changed = (bumping != r_prev_bump);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_brake  <= '0;
            r_prev_gas    <= '0;
            r_prev_status <= {NUM_WHEELS{ST_NONE}};
            r_prev_bump   <= 1'b0;
        end else if (i_upd) begin
            r_prev_brake  <= brake_max;
            r_prev_gas    <= gas_max;
            r_prev_status <= i_status;
            r_prev_bump   <= bumping;
        end
    end

endmodule

// ===== rtl/wheel_slip_haptic_level_unit.sv =====
// ----------------------------------------------------------------------------
// wheel_slip_haptic_level_unit
// Pedal vibration levels from four-wheel slip telemetry.
// ----------------------------------------------------------------------------
// One telemetry beat in, one level beat out. On its way to the result
// register, a sample has the radius by omega product taken at acceptance,
// the rim speed scaling in the next cycle, and the four-lane threshold
// compare and merge in the done step; a new sample is taken once the
// previous one has reached the output register, which may still hold it
// while the consumer stalls. Configuration writes land on the next edge and
// are meant for idle periods only.
module wheel_slip_haptic_level_unit
    import wshl_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]  i_cfg_wdata,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  t_in_beat               i_in_beat,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output t_out_beat              o_out_beat
);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_SCALE = 3'b010,
        S_DONE  = 3'b100
    } t_state;

    t_state                              r_state;
    t_state                              n_state;
    logic [NUM_WHEELS-1:0][RADIUS_W-1:0] r_radius;
    logic [6:0]                          r_brake_pct;
    logic [SLIP_W-1:0]                   r_gas_pct;
    logic [SLIP_W-1:0]                   r_bump_level;
    t_in_beat                            r_in;
    logic [THR_B_W-1:0]                  r_thr_b;
    logic [THR_G_W-1:0]                  r_thr_g;
    logic                                r_out_valid;
    t_out_beat                           r_out;

    logic                                in_acc;
    logic                                done_go;
    logic                                any_moving;
    logic [SPEED_W-1:0]                  speed_eff;
    logic [6:0]                          brake_sat;
    logic [6:0]                          brake_fac;
    t_lane_ctl                           lane_ctl;
    logic signed [NUM_WHEELS-1:0][OMEGA_W-1:0] omega_in;
    logic [NUM_WHEELS-1:0][SLIP_IN_W-1:0] slip_in;
    logic [NUM_WHEELS-1:0][SLIP_W-1:0]   lane_slip;
    t_wstat [NUM_WHEELS-1:0]             lane_status;
    t_out_beat                           merge_beat;

    assign o_in_stall  = (r_state != S_IDLE);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign done_go     = (r_state == S_DONE) && (!r_out_valid || !i_out_stall);
    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out;

    assign omega_in = {i_in_beat.omega_rr, i_in_beat.omega_rl,
                       i_in_beat.omega_fr, i_in_beat.omega_fl};
    assign slip_in  = {r_in.slip_rr, r_in.slip_rl, r_in.slip_fr, r_in.slip_fl};

    always_comb begin
        any_moving = 1'b0;
        for (int i = 0; i < NUM_WHEELS; i++) begin
            if (!omega_in[i][OMEGA_W-1] && (omega_in[i][OMEGA_W-2:3] != '0)) begin
                any_moving = 1'b1;
            end
        end
    end

    assign speed_eff = any_moving ? i_in_beat.speed_kmh : '0;
    assign brake_sat = (r_brake_pct > PCT_FULL) ? PCT_FULL : r_brake_pct;
    assign brake_fac = PCT_FULL - brake_sat;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = S_SCALE;
                end
            end
            S_SCALE: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (done_go) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_out_valid  <= 1'b0;
            r_radius     <= {NUM_WHEELS{RADIUS_RST}};
            r_brake_pct  <= 7'd10;
            r_gas_pct    <= 8'd110;
            r_bump_level <= '0;
        end else begin
            r_state <= n_state;
            if (done_go) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_RADIUS_FL: r_radius[0]  <= i_cfg_wdata;
                    CFG_RADIUS_FR: r_radius[1]  <= i_cfg_wdata;
                    CFG_RADIUS_RL: r_radius[2]  <= i_cfg_wdata;
                    CFG_RADIUS_RR: r_radius[3]  <= i_cfg_wdata;
                    CFG_BRAKE_PCT: r_brake_pct  <= i_cfg_wdata[6:0];
                    CFG_GAS_PCT:   r_gas_pct    <= i_cfg_wdata[SLIP_W-1:0];
                    CFG_BUMP_LVL:  r_bump_level <= i_cfg_wdata[SLIP_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in    <= i_in_beat;
            r_thr_b <= THR_B_W'(speed_eff) * THR_B_W'(brake_fac);
            r_thr_g <= THR_G_W'(speed_eff) * THR_G_W'(r_gas_pct);
        end
        if (done_go) begin
            r_out <= merge_beat;
        end
    end

    assign lane_ctl.load  = in_acc;
    assign lane_ctl.scale = (r_state == S_SCALE);

    for (genvar g = 0; g < NUM_WHEELS; g++) begin : g_lane
        wshl_lane u_lane (
            .i_clk       (i_clk),
            .i_ctl       (lane_ctl),
            .i_radius    (r_radius[g]),
            .i_omega     (omega_in[g]),
            .i_slip      (slip_in[g]),
            .i_thr_brake (r_thr_b),
            .i_thr_gas   (r_thr_g),
            .o_slip      (lane_slip[g]),
            .o_status    (lane_status[g])
        );
    end

    wshl_merge u_merge (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_upd        (done_go),
        .i_status     (lane_status),
        .i_slip       (lane_slip),
        .i_loads      (r_in.load_zero),
        .i_bump_level (r_bump_level),
        .o_beat       (merge_beat)
    );

    // accepted sample goes straight to scaling
    a_acc_to_scale: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state == S_SCALE))
        else $error("accepted beat did not enter scaling");

    // a new result only ever leaves the done step
    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_DONE))
        else $error("result appeared outside done step");

    // blocked result keeps the sample parked in the done step
    a_done_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_out_valid && i_out_stall) |=> (r_state == S_DONE))
        else $error("done step left while output blocked");

    // scaling always advances to the done step
    a_scale_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCALE) |=> (r_state == S_DONE))
        else $error("scaling step did not advance");

endmodule
